// ===== sv/acs_pkg.sv =====
package acs_pkg;

    // Operation codes carried in the request word
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Contact normal axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // At most this many contacts are reported for one query
    localparam int RESULT_CAP = 32;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    typedef struct packed {
        logic [1:0]         operation;
        logic [4:0]         slot;
        logic [15:0]        entity_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_z;
    } acs_in_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] mover_id;
        logic [15:0] obstacle_id;
        logic [31:0] depth;
        logic [1:0]  axis;
        logic        toward_negative;
        logic        last;
    } acs_out_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;
        logic clr_en;
        logic q_load;
        logic rd_en;
        logic rd_last;
        logic flush;
    } acs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic adv;
        logic scan_done;
        logic out_free;
    } acs_stat_t;

endpackage

// ===== sv/acs_ctrl.sv =====
module acs_ctrl #(
    parameter int OBSTACLE_SLOTS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic [1:0]                             operation,
    input  acs_pkg::acs_stat_t                     st,
    output acs_pkg::acs_cmd_t                      cmd,
    output logic [$clog2(OBSTACLE_SLOTS+1)-1:0]    rd_addr
);
    import acs_pkg::*;

    localparam int AW = $clog2(OBSTACLE_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(OBSTACLE_SLOTS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FLUSH} state_t;

    state_t        state_reg;
    logic [AW-1:0] cnt_reg;
    logic          accept;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign rd_addr   = cnt_reg;

    // Decode commands from state and handshake
    always_comb
    begin
        cmd         = '0;
        cmd.wr_en   = accept && (operation == OP_LOAD);
        cmd.clr_en  = accept && (operation == OP_CLEAR);
        cmd.q_load  = accept && (operation == OP_QUERY);
        cmd.rd_en   = (state_reg == ST_SCAN) && st.adv;
        cmd.rd_last = (cnt_reg == LAST_SLOT);
        cmd.flush   = (state_reg == ST_FLUSH);
    end

    // Sequence a query: scan, drain pipeline, flush final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cmd.q_load)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (st.adv)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == LAST_SLOT)
                            state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (st.scan_done)
                        state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    if (st.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(cmd.wr_en || cmd.clr_en || cmd.q_load))
        else $error("request taken while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= LAST_SLOT))
        else $error("scan index beyond table");
    a_flush_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_FLUSH) |-> $past(st.scan_done))
        else $error("flush without finished scan");

endmodule

// ===== sv/acs_datapath.sv =====
module acs_datapath #(
    parameter int OBSTACLE_SLOTS = 32,
    parameter int ID_WIDTH       = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acs_pkg::acs_in_t                    req,
    input  acs_pkg::acs_cmd_t                   cmd,
    input  logic [$clog2(OBSTACLE_SLOTS+1)-1:0] rd_addr,
    output acs_pkg::acs_stat_t                  st,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output acs_pkg::acs_out_t                   rsp
);
    import acs_pkg::*;

    localparam int IW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;

    // Table storage
    logic [OBSTACLE_SLOTS-1:0] valid_reg;
    logic [ID_WIDTH-1:0]       mem_id_reg  [OBSTACLE_SLOTS];
    logic signed [31:0]        mem_px_reg  [OBSTACLE_SLOTS];
    logic signed [31:0]        mem_py_reg  [OBSTACLE_SLOTS];
    logic signed [31:0]        mem_pz_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_lx_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_hx_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_ly_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_hy_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_lz_reg  [OBSTACLE_SLOTS];
    logic signed [32:0]        mem_hz_reg  [OBSTACLE_SLOTS];

    // Query registers
    logic [ID_WIDTH-1:0] qid_reg;
    logic signed [31:0]  qpx_reg, qpy_reg, qpz_reg;
    logic signed [32:0]  qlx_reg, qhx_reg, qly_reg, qhy_reg, qlz_reg, qhz_reg;

    // Read stage
    logic                v1_reg, last1_reg, sv1_reg;
    logic [ID_WIDTH-1:0] oid1_reg;
    logic signed [31:0]  opx1_reg, opy1_reg, opz1_reg;
    logic signed [32:0]  olx1_reg, ohx1_reg, oly1_reg, ohy1_reg, olz1_reg, ohz1_reg;

    // Overlap stage
    logic                v2_reg, last2_reg, hit2_reg;
    logic [ID_WIDTH-1:0] oid2_reg;
    logic signed [33:0]  ox2_reg, oy2_reg, oz2_reg;
    logic                nx2_reg, ny2_reg, nz2_reg;

    // Pending contact and output word
    logic                pend_valid_reg;
    acs_out_t            pend_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic                out_valid_reg;
    acs_out_t            out_reg;

    logic signed [32:0]  in_lx, in_hx, in_ly, in_hy, in_lz, in_hz;
    logic [31:0]         slot_wide;
    logic [IW-1:0]       slot_idx;
    logic                slot_ok;
    logic [ID_WIDTH-1:0] in_id;
    logic [IW-1:0]       rd_idx;
    logic signed [32:0]  mnx, mny, mnz, mxx, mxy, mxz;
    logic                ovl;
    logic signed [33:0]  dsel;
    logic [1:0]          axsel;
    logic                negsel;
    logic [31:0]         depth_sat;
    logic                cand;
    acs_out_t            cand_word;
    acs_out_t            flush_word;
    logic                out_free;
    logic                adv;
    logic                mid_push;
    logic                push;
    acs_out_t            push_word;

    // Decode request word
    assign in_id     = ID_WIDTH'(req.entity_id);
    assign in_lx     = {req.pos_x[31], req.pos_x} + {req.box_min_x[31], req.box_min_x};
    assign in_hx     = {req.pos_x[31], req.pos_x} + {req.box_max_x[31], req.box_max_x};
    assign in_ly     = {req.pos_y[31], req.pos_y} + {req.box_min_y[31], req.box_min_y};
    assign in_hy     = {req.pos_y[31], req.pos_y} + {req.box_max_y[31], req.box_max_y};
    assign in_lz     = {req.pos_z[31], req.pos_z} + {req.box_min_z[31], req.box_min_z};
    assign in_hz     = {req.pos_z[31], req.pos_z} + {req.box_max_z[31], req.box_max_z};
    assign slot_wide = 32'(req.slot);
    assign slot_idx  = slot_wide[IW-1:0];
    assign slot_ok   = (slot_wide < 32'(OBSTACLE_SLOTS));
    assign rd_idx    = rd_addr[IW-1:0];

    // Hold slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (slot_ok && cmd.wr_en)
            valid_reg[slot_idx] <= 1'b1;
        else if (slot_ok && cmd.clr_en)
            valid_reg[slot_idx] <= 1'b0;
    end

    // Write table entry, stored as world bounds
    always_ff @(posedge clk)
    begin
        if (slot_ok && cmd.wr_en)
        begin
            mem_id_reg[slot_idx] <= in_id;
            mem_px_reg[slot_idx] <= req.pos_x;
            mem_py_reg[slot_idx] <= req.pos_y;
            mem_pz_reg[slot_idx] <= req.pos_z;
            mem_lx_reg[slot_idx] <= in_lx;
            mem_hx_reg[slot_idx] <= in_hx;
            mem_ly_reg[slot_idx] <= in_ly;
            mem_hy_reg[slot_idx] <= in_hy;
            mem_lz_reg[slot_idx] <= in_lz;
            mem_hz_reg[slot_idx] <= in_hz;
        end
    end

    // Read table entry for the slot under scan
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            oid1_reg <= mem_id_reg[rd_idx];
            opx1_reg <= mem_px_reg[rd_idx];
            opy1_reg <= mem_py_reg[rd_idx];
            opz1_reg <= mem_pz_reg[rd_idx];
            olx1_reg <= mem_lx_reg[rd_idx];
            ohx1_reg <= mem_hx_reg[rd_idx];
            oly1_reg <= mem_ly_reg[rd_idx];
            ohy1_reg <= mem_hy_reg[rd_idx];
            olz1_reg <= mem_lz_reg[rd_idx];
            ohz1_reg <= mem_hz_reg[rd_idx];
            sv1_reg  <= valid_reg[rd_idx];
            last1_reg <= cmd.rd_last;
        end
    end

    // Latch query box
    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            qid_reg <= in_id;
            qpx_reg <= req.pos_x;
            qpy_reg <= req.pos_y;
            qpz_reg <= req.pos_z;
            qlx_reg <= in_lx;
            qhx_reg <= in_hx;
            qly_reg <= in_ly;
            qhy_reg <= in_hy;
            qlz_reg <= in_lz;
            qhz_reg <= in_hz;
        end
    end

    // Overlap per axis
    assign mnx = (qhx_reg < ohx1_reg) ? qhx_reg : ohx1_reg;
    assign mny = (qhy_reg < ohy1_reg) ? qhy_reg : ohy1_reg;
    assign mnz = (qhz_reg < ohz1_reg) ? qhz_reg : ohz1_reg;
    assign mxx = (qlx_reg > olx1_reg) ? qlx_reg : olx1_reg;
    assign mxy = (qly_reg > oly1_reg) ? qly_reg : oly1_reg;
    assign mxz = (qlz_reg > olz1_reg) ? qlz_reg : olz1_reg;
    assign ovl = (qlx_reg <= ohx1_reg) && (qhx_reg >= olx1_reg) &&
                 (qly_reg <= ohy1_reg) && (qhy_reg >= oly1_reg) &&
                 (qlz_reg <= ohz1_reg) && (qhz_reg >= olz1_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox2_reg   <= {mnx[32], mnx} - {mxx[32], mxx};
            oy2_reg   <= {mny[32], mny} - {mxy[32], mxy};
            oz2_reg   <= {mnz[32], mnz} - {mxz[32], mxz};
            nx2_reg   <= (qpx_reg < opx1_reg);
            ny2_reg   <= (qpy_reg < opy1_reg);
            nz2_reg   <= (qpz_reg < opz1_reg);
            oid2_reg  <= oid1_reg;
            hit2_reg  <= sv1_reg && ovl && (oid1_reg != qid_reg);
            last2_reg <= last1_reg;
        end
    end

    // Pick the shallowest axis, ties go to the later axis (Z over Y over X), and saturate
    always_comb
    begin
        if ((ox2_reg < oy2_reg) && (ox2_reg < oz2_reg))
        begin
            dsel   = ox2_reg;
            axsel  = AXIS_X;
            negsel = nx2_reg;
        end
        else if (oy2_reg < oz2_reg)
        begin
            dsel   = oy2_reg;
            axsel  = AXIS_Y;
            negsel = ny2_reg;
        end
        else
        begin
            dsel   = oz2_reg;
            axsel  = AXIS_Z;
            negsel = nz2_reg;
        end
        if (dsel[33])
            depth_sat = '0;
        else if (dsel[32])
            depth_sat = '1;
        else
            depth_sat = dsel[31:0];
    end

    assign cand = v2_reg && hit2_reg && (hit_cnt_reg < CNT_W'(RESULT_CAP));

    always_comb
    begin
        cand_word                 = '0;
        cand_word.hit             = 1'b1;
        cand_word.mover_id        = 16'(qid_reg);
        cand_word.obstacle_id     = 16'(oid2_reg);
        cand_word.depth           = depth_sat;
        cand_word.axis            = axsel;
        cand_word.toward_negative = negsel;
        cand_word.last            = 1'b0;
        if (pend_valid_reg)
        begin
            flush_word      = pend_reg;
            flush_word.last = 1'b1;
        end
        else
        begin
            flush_word          = '0;
            flush_word.mover_id = 16'(qid_reg);
            flush_word.last     = 1'b1;
        end
    end

    // Stall the scan while a new contact would overrun a blocked output
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign adv       = !(cand && pend_valid_reg && !out_free);
    assign mid_push  = adv && cand && pend_valid_reg;
    assign push      = mid_push || (cmd.flush && out_free);
    assign push_word = cmd.flush ? flush_word : pend_reg;

    assign st.adv       = adv;
    assign st.scan_done = adv && v2_reg && last2_reg;
    assign st.out_free  = out_free;

    // Advance pipeline valids and pending contact
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            hit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= cmd.rd_en;
                v2_reg <= v1_reg;
            end
            if (cmd.q_load)
            begin
                pend_valid_reg <= 1'b0;
                hit_cnt_reg    <= '0;
            end
            else if (adv && cand)
            begin
                pend_valid_reg <= 1'b1;
                hit_cnt_reg    <= hit_cnt_reg + 1'b1;
            end
            if (push)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && cand)
            pend_reg <= cand_word;
        if (push)
            out_reg <= push_word;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("output word overwritten");
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        st.scan_done |-> !v1_reg)
        else $error("scan finished with slot in flight");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= CNT_W'(RESULT_CAP))
        else $error("contact count beyond cap");
    a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (hit_cnt_reg != '0))
        else $error("pending contact without count");

endmodule

// ===== sv/aabb_contact_scan.sv =====
// Box contact scanner. A load word writes an obstacle (id, position and box
// offsets, kept as world bounds) into a table slot, a clear word invalidates a
// slot. A query word scans every slot through the single table read port, one
// slot per cycle while the output side does not stall a contact, and new
// requests stall until the query is done. Each valid overlapping obstacle with
// a different id gives one contact word with the shallowest axis depth; a query
// with none gives one empty word. The final word of a query carries last. Up to
// 32 contacts are reported.
module aabb_contact_scan #(
    parameter int OBSTACLE_SLOTS = 32,
    parameter int ID_WIDTH       = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  acs_pkg::acs_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output acs_pkg::acs_out_t rsp
);
    import acs_pkg::*;

    localparam int AW = $clog2(OBSTACLE_SLOTS + 1);

    acs_cmd_t      cmd;
    acs_stat_t     st;
    logic [AW-1:0] rd_addr;

    acs_ctrl #(
        .OBSTACLE_SLOTS(OBSTACLE_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (req.operation),
        .st        (st),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    acs_datapath #(
        .OBSTACLE_SLOTS(OBSTACLE_SLOTS),
        .ID_WIDTH      (ID_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import acs_pkg::*;

    localparam int SLOTS        = 32;
    localparam int RANDOM_WORDS = 170;
    localparam int WATCHDOG_MAX = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    acs_in_t  req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    acs_out_t rsp;

    // Shadow of the obstacle table
    logic               tbl_valid [SLOTS];
    logic        [15:0] tbl_id    [SLOTS];
    logic signed [63:0] tbl_pos   [SLOTS][3];
    logic signed [63:0] tbl_lo    [SLOTS][3];
    logic signed [63:0] tbl_hi    [SLOTS][3];

    acs_out_t contact_queue [$];
    int       error_count;
    int       contact_count;
    int       query_count;
    int       idle_count;
    bit       calm;
    bit       hold_off;

    // Directed stimulus: word and, where obvious, its expected single result
    typedef struct {
        acs_in_t  w;
        bit       fixed;
        acs_out_t exp_rsp;
    } row_t;
    row_t dir_rows [$];

    aabb_contact_scan dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    task automatic report(input string what, input acs_out_t got, input acs_out_t want);
        error_count++;
        $display("mismatch %s: got %p want %p", what, got, want);
    endtask

    function automatic logic signed [63:0] sx(input logic signed [31:0] v);
        return 64'(v);
    endfunction

    // Work out the contacts a word causes, and update the shadow table
    task automatic predict_contacts(input acs_in_t w);
        logic signed [63:0] pos [3];
        logic signed [63:0] lo [3];
        logic signed [63:0] hi [3];
        logic signed [63:0] ov [3];
        logic signed [63:0] d;
        acs_out_t r;
        int n;
        int ax;
        bit touch;
        pos[0] = sx(w.pos_x); pos[1] = sx(w.pos_y); pos[2] = sx(w.pos_z);
        lo[0] = pos[0] + sx(w.box_min_x); hi[0] = pos[0] + sx(w.box_max_x);
        lo[1] = pos[1] + sx(w.box_min_y); hi[1] = pos[1] + sx(w.box_max_y);
        lo[2] = pos[2] + sx(w.box_min_z); hi[2] = pos[2] + sx(w.box_max_z);
        n = 0;
        case (w.operation)
            OP_LOAD:
            begin
                tbl_valid[w.slot] = 1'b1;
                tbl_id[w.slot] = w.entity_id;
                for (int a = 0; a < 3; a++)
                begin
                    tbl_pos[w.slot][a] = pos[a];
                    tbl_lo[w.slot][a] = lo[a];
                    tbl_hi[w.slot][a] = hi[a];
                end
            end
            OP_CLEAR:
                tbl_valid[w.slot] = 1'b0;
            OP_QUERY:
            begin
                query_count++;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!tbl_valid[s] || tbl_id[s] == w.entity_id)
                        continue;
                    touch = 1'b1;
                    for (int a = 0; a < 3; a++)
                        if (!(lo[a] <= tbl_hi[s][a] && hi[a] >= tbl_lo[s][a]))
                            touch = 1'b0;
                    if (!touch)
                        continue;
                    for (int a = 0; a < 3; a++)
                        ov[a] = ((hi[a] < tbl_hi[s][a]) ? hi[a] : tbl_hi[s][a])
                              - ((lo[a] > tbl_lo[s][a]) ? lo[a] : tbl_lo[s][a]);
                    if (ov[0] < ov[1] && ov[0] < ov[2])
                        ax = 0;
                    else if (ov[1] < ov[2])
                        ax = 1;
                    else
                        ax = 2;
                    d = ov[ax];
                    r = '0;
                    r.hit = 1'b1;
                    r.mover_id = w.entity_id;
                    r.obstacle_id = tbl_id[s];
                    r.depth = (d < 0) ? 32'd0 :
                              (d > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
                    r.axis = (ax == 0) ? AXIS_X : (ax == 1) ? AXIS_Y : AXIS_Z;
                    r.toward_negative = pos[ax] < tbl_pos[s][ax];
                    contact_queue.push_back(r);
                    n++;
                end
                if (n == 0)
                begin
                    r = '0;
                    r.mover_id = w.entity_id;
                    contact_queue.push_back(r);
                end
                contact_queue[$].last = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    function automatic acs_in_t make_word(input logic [1:0] op, input logic [4:0] sl,
                                          input logic [15:0] id, input logic [31:0] p,
                                          input logic [31:0] lo_off, input logic [31:0] hi_off);
        acs_in_t w;
        w.operation = op; w.slot = sl; w.entity_id = id;
        w.pos_x = p; w.pos_y = p; w.pos_z = p;
        w.box_min_x = lo_off; w.box_min_y = lo_off; w.box_min_z = lo_off;
        w.box_max_x = hi_off; w.box_max_y = hi_off; w.box_max_z = hi_off;
        return w;
    endfunction

    function automatic acs_in_t rand_word();
        acs_in_t w;
        for (int i = 0; i < $bits(acs_in_t); i += 32)
            w = (w << 32) | $urandom;
        return w;
    endfunction

    // Small random coordinates so that boxes actually meet
    function automatic logic [31:0] near(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic acs_in_t shaped_word();
        acs_in_t w;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return rand_word();
        w.slot = 5'($urandom);
        w.entity_id = 16'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
            w.entity_id = 16'($urandom);
        w.operation = (pick < 45) ? OP_LOAD : (pick < 55) ? OP_CLEAR :
                      (pick < 58) ? 2'd3 : OP_QUERY;
        w.pos_x = near(40000); w.pos_y = near(40000); w.pos_z = near(40000);
        w.box_min_x = -$signed(near(30000) & 32'h7FFF);
        w.box_min_y = -$signed(near(30000) & 32'h7FFF);
        w.box_min_z = -$signed(near(30000) & 32'h7FFF);
        w.box_max_x = near(30000) & 32'h7FFF;
        w.box_max_y = near(30000) & 32'h7FFF;
        w.box_max_z = near(30000) & 32'h7FFF;
        if ($urandom_range(0, 19) == 0)
            w.box_max_y = -32'sd5000;
        return w;
    endfunction

    task automatic send_word(input acs_in_t w);
        while (!calm && $urandom_range(0, 99) < 15)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        predict_contacts(w);
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (contact_queue.size() == 0)
                report("unexpected", rsp, '0);
            else
            begin
                if (rsp !== contact_queue[0])
                    report("field", rsp, contact_queue[0]);
                void'(contact_queue.pop_front());
                contact_count++;
            end
        end
    end

    // Receiver stall, with one long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > WATCHDOG_MAX)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        acs_in_t w;
        acs_out_t e;
        row_t row;
        error_count = 0; contact_count = 0; query_count = 0; idle_count = 0;
        calm = 1'b0; hold_off = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            tbl_valid[s] = 1'b0;

        // Empty table: query gives one empty word
        e = '0; e.mover_id = 16'hFFFF; e.last = 1'b1;
        dir_rows.push_back('{make_word(OP_QUERY, 5'd3, 16'hFFFF, 0, 0, 0), 1, e});
        dir_rows.push_back('{make_word(2'd3, 5'd0, 16'd1, 0, -100, 100), 0, e});
        // Widest boxes on top of each other give the largest depth
        dir_rows.push_back('{make_word(OP_LOAD, 5'd0, 16'd1, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF), 0, e});
        e = '0; e.hit = 1'b1; e.mover_id = 16'd2; e.obstacle_id = 16'd1;
        e.depth = 32'hFFFF_FFFF; e.axis = AXIS_Z; e.toward_negative = 1'b0; e.last = 1'b1;
        dir_rows.push_back('{make_word(OP_QUERY, 5'd31, 16'd2, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF), 1, e});
        // Same id skipped
        e = '0; e.mover_id = 16'd1; e.last = 1'b1;
        dir_rows.push_back('{make_word(OP_QUERY, 5'd0, 16'd1, 0, -10, 10), 1, e});
        // Inclusive touch at one point, and an inverted box
        dir_rows.push_back('{make_word(OP_LOAD, 5'd31, 16'd0, 32'd100, 0, 32'd10), 0, e});
        dir_rows.push_back('{make_word(OP_QUERY, 5'd0, 16'd9, 32'd90, 0, 32'd10), 0, e});
        dir_rows.push_back('{make_word(OP_QUERY, 5'd0, 16'd9, 32'd105, 32'd8, -32'sd8), 0, e});
        w = make_word(OP_QUERY, 5'd0, 16'h8000, 32'd103, -32'sd1, 32'd2);
        w.box_max_x = 32'd1;
        dir_rows.push_back('{w, 0, e});
        w.pos_y = 32'd99; w.box_max_z = 32'd5;
        dir_rows.push_back('{w, 0, e});
        // Clear both slots, check empty again
        dir_rows.push_back('{make_word(OP_CLEAR, 5'd0, 16'd0, 0, 0, 0), 0, e});
        dir_rows.push_back('{make_word(OP_CLEAR, 5'd31, 16'hFFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, e});
        e = '0; e.mover_id = 16'd7; e.last = 1'b1;
        dir_rows.push_back('{make_word(OP_QUERY, 5'd0, 16'd7, 0, -5, 5), 1, e});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_word(row.w);
            if (row.fixed && row.w.operation == OP_QUERY && contact_queue[$] != row.exp_rsp)
                report("directed", contact_queue[$], row.exp_rsp);
        end

        // Load slots 0 to 19, then stall the output for a long stretch
        for (int s = 0; s < 20; s++)
        begin
            w = shaped_word();
            w.operation = OP_LOAD;
            w.slot = 5'(s);
            send_word(w);
        end
        hold_off = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
            begin
                w = shaped_word();
                w.operation = OP_QUERY;
                send_word(w);
            end
        join

        // Random part, with a calm stretch in the middle
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 80 && i < 120);
            send_word(shaped_word());
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (contact_queue.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("run: %0d queries, %0d results checked, boxes touching, inverted,",
                 query_count, contact_count);
        $display("widest-box and same-id cases, with random stalls and a long hold-off");
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/acs_pkg.sv
sv/acs_ctrl.sv
sv/acs_datapath.sv
sv/aabb_contact_scan.sv
bench/testbench.sv
